// ===== design/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg
// shared widths, blend equation codes and register map of the rgba blend unit
// ----------------------------------------------------------------------------
package rbe_pkg;

	localparam int PIX_W  = 32;             // packed rgba8 word
	localparam int CH_W   = 8;              // one color channel
	localparam int LANES  = PIX_W / CH_W;   // red, green, blue, alpha
	localparam int PROD_W = 2 * CH_W;       // channel times factor
	localparam int SUM_W  = PROD_W + 1;     // sum of two products

	// smallest combined value whose quotient by 255 exceeds 255
	localparam logic [SUM_W-1:0] SAT_LIM = SUM_W'(255 * 256);

	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	localparam int MODE_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 3'd0,
		MODE_SUB    = 3'd1,
		MODE_REVSUB = 3'd2,
		MODE_MIN    = 3'd3,
		MODE_MAX    = 3'd4
	} blend_mode_t;

	// word index of each register
	localparam logic [APB_AW-3:0] REG_BLEND_MODE = 1'b0;

endpackage

// ===== design/rbe_if.sv =====
// ----------------------------------------------------------------------------
// rbe channel interfaces
// valid/ready channels for the pixel word in and the blended word out
// ----------------------------------------------------------------------------
interface rbe_in_if;
	import rbe_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] source_color;
	logic [PIX_W-1:0] source_factor;
	logic [PIX_W-1:0] dest_color;
	logic [PIX_W-1:0] dest_factor;

	modport source (
		output valid, source_color, source_factor, dest_color, dest_factor,
		input  ready
	);
	modport sink (
		input  valid, source_color, source_factor, dest_color, dest_factor,
		output ready
	);
endinterface

interface rbe_out_if;
	import rbe_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic [CH_W-1:0] out_alpha;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

// ===== design/rgba_blend_equation_top.sv =====
// ----------------------------------------------------------------------------
// rgba_blend_equation_top
// per-channel blend of a source and a destination rgba8 pixel, three stages
// ----------------------------------------------------------------------------
// path: an accepted word is registered in the multiply, combine and divide
// stages in turn, and its result word is driven from the divide stage register
// throughput: one word per cycle; stages: multiply, combine, divide by 255 and clamp
// a full pipeline holds its contents while the output is stalled; bubbles are
// squeezed out, so input stays ready while any stage is empty
// reset: asynchronous active-low arst_n clears stage valid bits and blend mode (add)
// ----------------------------------------------------------------------------
module rgba_blend_equation_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// apb configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rbe_pkg::APB_AW-1:0]   paddr,
	input  logic [rbe_pkg::APB_DW-1:0]   pwdata,
	output logic [rbe_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	// pixel channels
	rbe_in_if.sink                       pix_in,
	rbe_out_if.source                    pix_out
);
	import rbe_pkg::*;

	// ------------------------------------------------------------------
	// configuration register
	// ------------------------------------------------------------------
	logic [MODE_W-1:0] mode_q;
	logic              reg_sel;
	logic              cfg_wr;

	// word addressed; byte offset bits are ignored
	assign reg_sel = (paddr[APB_AW-1:2] == REG_BLEND_MODE);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ADD;
		end else if (cfg_wr && reg_sel) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[MODE_W-1:0] = mode_q;
		end
	end

	// ------------------------------------------------------------------
	// stage enables: a stage loads when it is empty or its word moves on
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3;
	logic en_s1, en_s2, en_s3;

	assign en_s3        = !vld_s3 || pix_out.ready;
	assign en_s2        = !vld_s2 || en_s3;
	assign en_s1        = !vld_s1 || en_s2;
	assign pix_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= pix_in.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: color times factor, one 8x8 multiplier per product
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] sprod_s1 [LANES];
	logic [PROD_W-1:0] dprod_s1 [LANES];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < LANES; k++) begin
				sprod_s1[k] <= pix_in.source_color[k*CH_W +: CH_W]
				             * pix_in.source_factor[k*CH_W +: CH_W];
				dprod_s1[k] <= pix_in.dest_color[k*CH_W +: CH_W]
				             * pix_in.dest_factor[k*CH_W +: CH_W];
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 2: blend equation on the two products
	// negative differences go straight to zero, unknown modes give zero
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] comb_val [LANES];
	logic [SUM_W-1:0] sum_s2   [LANES];

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			case (mode_q)
				MODE_ADD:
					comb_val[k] = {1'b0, sprod_s1[k]} + {1'b0, dprod_s1[k]};
				MODE_SUB:
					comb_val[k] = (sprod_s1[k] >= dprod_s1[k])
					            ? {1'b0, sprod_s1[k] - dprod_s1[k]} : '0;
				MODE_REVSUB:
					comb_val[k] = (dprod_s1[k] >= sprod_s1[k])
					            ? {1'b0, dprod_s1[k] - sprod_s1[k]} : '0;
				MODE_MIN:
					comb_val[k] = (sprod_s1[k] < dprod_s1[k])
					            ? {1'b0, sprod_s1[k]} : {1'b0, dprod_s1[k]};
				MODE_MAX:
					comb_val[k] = (sprod_s1[k] > dprod_s1[k])
					            ? {1'b0, sprod_s1[k]} : {1'b0, dprod_s1[k]};
				default:
					comb_val[k] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int k = 0; k < LANES; k++) begin
				sum_s2[k] <= comb_val[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 3: divide by 255 and clamp
	// anything at or above 255*256 saturates; below that,
	// (v + (v >> 8) + 1) >> 8 is the exact truncated quotient
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] div_acc [LANES];
	logic [CH_W-1:0]  quot    [LANES];
	logic [CH_W-1:0]  res_s3  [LANES];

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			div_acc[k] = {1'b0, sum_s2[k][PROD_W-1:0]}
			           + {{(SUM_W-CH_W){1'b0}}, sum_s2[k][PROD_W-1:CH_W]}
			           + SUM_W'(1);
			quot[k]    = (sum_s2[k] >= SAT_LIM) ? {CH_W{1'b1}}
			                                    : div_acc[k][PROD_W-1:CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int k = 0; k < LANES; k++) begin
				res_s3[k] <= quot[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// result word
	// ------------------------------------------------------------------
	assign pix_out.valid     = vld_s3;
	assign pix_out.out_red   = res_s3[0];
	assign pix_out.out_green = res_s3[1];
	assign pix_out.out_blue  = res_s3[2];
	assign pix_out.out_alpha = res_s3[3];

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for rgba_blend_equation_top
// drives pixel words under every blend mode code, including the unknown ones,
// with random gaps and stalls on both channels and a long output hold-off;
// a scoreboard predicts each blended word and compares it lane by lane
// ----------------------------------------------------------------------------
module testbench;
	import rbe_pkg::*;

	localparam int CH_MAX           = 255;
	localparam int LATENCY          = 3;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int REPORT_LIMIT     = 10;
	localparam int RANDOM_PHASES    = 12;
	localparam int PHASE_WORDS      = 86;
	localparam int MODE_CODES       = 2 ** MODE_W;

	// byte address of the blend mode register
	localparam logic [APB_AW-1:0] MODE_ADDR = {REG_BLEND_MODE, 2'b00};

	typedef logic [LANES-1:0][CH_W-1:0] rgba_t;   // lane 0 is red

	typedef struct {
		logic [PIX_W-1:0] source_color;
		logic [PIX_W-1:0] source_factor;
		logic [PIX_W-1:0] dest_color;
		logic [PIX_W-1:0] dest_factor;
	} pixel_word_t;

	typedef enum {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_style_t;

	// ------------------------------------------------------------------------
	// scoreboard: blend prediction and the queue of expected output words
	// ------------------------------------------------------------------------
	class blend_board;
		logic [MODE_W-1:0] mode;
		rgba_t             due[$];
		int                errors;
		int                checked;

		function new();
			mode    = MODE_ADD;
			errors  = 0;
			checked = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		function logic [CH_W-1:0] blend_channel(logic [PROD_W-1:0] s, logic [PROD_W-1:0] d);
			logic [SUM_W-1:0] v;
			logic             keep;
			int               q;
			keep = 1'b1;
			v    = '0;
			case (mode)
				MODE_ADD:    v = s + d;
				MODE_SUB:    if (s >= d) v = s - d; else keep = 1'b0;
				MODE_REVSUB: if (d >= s) v = d - s; else keep = 1'b0;
				MODE_MIN:    v = (s < d) ? s : d;
				MODE_MAX:    v = (s > d) ? s : d;
				default:     keep = 1'b0;
			endcase
			if (!keep)
				return '0;
			q = v / CH_MAX;
			if (q > CH_MAX)
				return '1;
			return q[CH_W-1:0];
		endfunction

		function void note_pixel(pixel_word_t p);
			rgba_t            r;
			logic [PROD_W-1:0] s;
			logic [PROD_W-1:0] d;
			for (int k = 0; k < LANES; k++) begin
				s = p.source_color[k*CH_W +: CH_W] * p.source_factor[k*CH_W +: CH_W];
				d = p.dest_color[k*CH_W +: CH_W] * p.dest_factor[k*CH_W +: CH_W];
				r[k] = blend_channel(s, d);
			end
			due.push_back(r);
		endfunction

		function void check_result(rgba_t got);
			rgba_t exp_word;
			string lane_name[LANES] = '{"red", "green", "blue", "alpha"};
			checked++;
			if (due.size() == 0) begin
				flag($sformatf("output word %h with nothing expected", got));
				return;
			end
			exp_word = due.pop_front();
			for (int k = 0; k < LANES; k++)
				if (got[k] !== exp_word[k])
					flag($sformatf("%s expected %0d got %0d (mode %0d)",
						lane_name[k], exp_word[k], got[k], mode));
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and the signals around the block
	// ------------------------------------------------------------------------
	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	rbe_in_if  pix_in_bus();
	rbe_out_if pix_out_bus();

	blend_board  board = new();
	idle_style_t in_style;
	idle_style_t out_style;
	logic        long_hold;
	int          holds_done;
	int          idle_cycles;
	int          mode_words[MODE_CODES];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rgba_blend_equation_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus)
	);

	// ------------------------------------------------------------------------
	// random helpers
	// ------------------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(idle_style_t style);
		int r;
		r = $urandom_range(0, 99);
		case (style)
			IDLE_NONE:  return 0;
			IDLE_LIGHT: begin
				if (r < 70) return 0;
				if (r < 95) return $urandom_range(1, 3);
				return $urandom_range(8, 40);
			end
			default: begin
				if (r < 30) return 0;
				if (r < 85) return $urandom_range(1, 4);
				return $urandom_range(10, 40);
			end
		endcase
	endfunction

	// channel values lean toward the edges of the 0..255 range
	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 8'd1;
			3:       return 8'hfe;
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_packed();
		logic [PIX_W-1:0] w;
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		for (int k = 0; k < LANES; k++)
			w[k*CH_W +: CH_W] = pick_channel();
		return w;
	endfunction

	function automatic pixel_word_t pick_pixel();
		pixel_word_t p;
		p.source_color  = pick_packed();
		p.source_factor = pick_packed();
		// equal products (same or swapped color and factor) make subtract and min/max interesting
		case ($urandom_range(0, 5))
			0: begin
				p.dest_color  = p.source_color;
				p.dest_factor = p.source_factor;
			end
			1: begin
				p.dest_color  = p.source_factor;
				p.dest_factor = p.source_color;
			end
			default: begin
				p.dest_color  = pick_packed();
				p.dest_factor = pick_packed();
			end
		endcase
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// apb register access: setup cycle then access cycle
	// ------------------------------------------------------------------------
	task automatic apb_access(input logic write, input logic [APB_AW-1:0] addr,
	                          input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = write;
		paddr   = addr;
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// write the blend mode, mirror it in the scoreboard and read it back
	task automatic set_mode(input logic [MODE_W-1:0] m);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, MODE_ADDR, APB_DW'(m), rd);
		board.mode = m;
		apb_access(1'b0, MODE_ADDR, '0, rd);
		if (rd !== APB_DW'(m))
			board.flag($sformatf("blend mode read back %h, wrote %0d", rd, m));
	endtask

	// ------------------------------------------------------------------------
	// input side: offer one word after a random gap, hold it until taken
	// ------------------------------------------------------------------------
	task automatic offer_pixel(input pixel_word_t p);
		int gap;
		gap = pick_gap(in_style);
		if (gap > 0) begin
			@(negedge clk);
			pix_in_bus.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_in_bus.valid         = 1'b1;
		pix_in_bus.source_color  = p.source_color;
		pix_in_bus.source_factor = p.source_factor;
		pix_in_bus.dest_color    = p.dest_color;
		pix_in_bus.dest_factor   = p.dest_factor;
		@(posedge clk);
		while (!pix_in_bus.ready)
			@(posedge clk);
		// word accepted at this edge
		board.note_pixel(p);
		mode_words[board.mode]++;
	endtask

	// drop valid and wait until every predicted word has come out
	task automatic drain();
		@(negedge clk);
		pix_in_bus.valid = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// output side: random ready pattern, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int run_left;
		int gap;
		run_left          = 0;
		pix_out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				// keep ready low long enough for the pipeline to fill and back up
				pix_out_bus.ready = 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				holds_done++;
				run_left = 0;
			end
			if (run_left == 0) begin
				gap = pick_gap(out_style);
				if (gap > 0) begin
					pix_out_bus.ready = 1'b0;
					run_left          = gap;
				end else begin
					pix_out_bus.ready = 1'b1;
					run_left          = $urandom_range(1, 16);
				end
			end
			run_left--;
		end
	end

	// result words are checked at the edge that accepts them
	always @(posedge clk) begin
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready)
			board.check_result({pix_out_bus.out_alpha, pix_out_bus.out_blue,
				pix_out_bus.out_green, pix_out_bus.out_red});
	end

	// watchdog: any handshake or register access counts as progress
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((pix_in_bus.valid && pix_in_bus.ready) ||
			    (pix_out_bus.valid && pix_out_bus.ready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout after %0d cycles without progress", WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		pixel_word_t corner[3];
		pixel_word_t p;
		int          total;
		// everything known from time zero
		arst_n                   = 1'b0;
		psel                     = 1'b0;
		penable                  = 1'b0;
		pwrite                   = 1'b0;
		paddr                    = '0;
		pwdata                   = '0;
		pix_in_bus.valid         = 1'b0;
		pix_in_bus.source_color  = '0;
		pix_in_bus.source_factor = '0;
		pix_in_bus.dest_color    = '0;
		pix_in_bus.dest_factor   = '0;
		long_hold                = 1'b0;
		holds_done               = 0;
		in_style                 = IDLE_NONE;
		out_style                = IDLE_NONE;
		foreach (mode_words[i])
			mode_words[i] = 0;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// all channels and factors at full scale: sum overflows and clamps,
		// differences are zero, min and max land exactly on 255
		corner[0] = '{'1, '1, '1, '1};
		// red: source product zero against a full destination (negative difference)
		// green: full source against a zero destination factor
		// blue: small products, 254 against 255, so the divide truncates to 0 or 1
		// alpha: products differ by one, 16384 against 16383
		corner[1] = '{32'h8001_ff00, 32'h80fe_ffff, 32'h7f01_ffff, 32'h81ff_00ff};
		// all zero
		corner[2] = '{'0, '0, '0, '0};

		// directed part: the corner words under every mode code, the unknown ones too
		for (int m = 0; m < MODE_CODES; m++) begin
			set_mode(MODE_W'(m));
			foreach (corner[i])
				offer_pixel(corner[i]);
			drain();
		end

		// random part: one mode per phase, every code first, then random codes
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < MODE_CODES)
				set_mode(MODE_W'(ph));
			else
				set_mode(MODE_W'($urandom_range(0, MODE_CODES - 1)));
			in_style  = idle_style_t'(ph % 3);
			out_style = idle_style_t'($urandom_range(0, 2));
			// one phase with a back-to-back sender and the output held off
			if (ph == 5) begin
				in_style  = IDLE_NONE;
				long_hold = 1'b1;
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				p = pick_pixel();
				offer_pixel(p);
			end
			drain();
		end

		// back to the reset value, a last few words
		set_mode(MODE_ADD);
		for (int n = 0; n < 8; n++) begin
			p = pick_pixel();
			offer_pixel(p);
		end
		drain();

		// let any stray word show up before closing
		repeat (LATENCY + 10) @(posedge clk);
		if (board.pending() != 0)
			board.flag($sformatf("%0d expected words never came out", board.pending()));

		total = 0;
		foreach (mode_words[i])
			total += mode_words[i];
		$display("blended %0d pixel words over all %0d mode codes, %0d output words checked",
			total, MODE_CODES, board.checked);
		$display("long output hold-offs: %0d, mismatches: %0d", holds_done, board.errors);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
